// ===== rtl/core/tprg_pkg.sv =====
// Shared constants and types for the tensor permute region generator.
package tprg_pkg;

    localparam int MAX_RANK_DEF    = 6;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int FIELD_BITS      = 3;
    localparam int ORDER_BITS      = 18;
    localparam int LO_BITS         = 64;
    localparam int HI_BITS         = 32;
    localparam int INDEX_BITS      = 16;
    localparam int WORD_BITS       = 32;
    localparam int COUNT_BITS      = 17;
    localparam int SIZE_BITS       = 16;
    localparam int CFG_INDEX_BITS  = 3;

    localparam logic [2:0]            RANK_RESET  = 3'd1;
    localparam logic [ORDER_BITS-1:0] ORDER_RESET = 18'd181896;
    localparam logic [LO_BITS-1:0]    LO_RESET    = 64'd281479271743489;
    localparam logic [HI_BITS-1:0]    HI_RESET    = 32'd65537;

    localparam logic [COUNT_BITS-1:0] REGION_CAP = 17'd65536;
    localparam logic [SIZE_BITS-1:0]  SIZE_CAP   = 16'hFFFF;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RANK  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORDER = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LO    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HI    = 3'd3;

    typedef struct packed {
        logic [COUNT_BITS-1:0] region_count;
        logic [SIZE_BITS-1:0]  outer_size;
        logic [SIZE_BITS-1:0]  middle_size;
        logic [WORD_BITS-1:0]  inner_size;
        logic [WORD_BITS-1:0]  src_outer_stride;
        logic [WORD_BITS-1:0]  src_middle_stride;
        logic [WORD_BITS-1:0]  src_inner_stride;
        logic [WORD_BITS-1:0]  dst_outer_stride;
        logic [WORD_BITS-1:0]  dst_middle_stride;
        logic [WORD_BITS-1:0]  dst_inner_stride;
    } desc_t;

endpackage

// ===== rtl/core/tprg_fuse.sv =====
// Configuration registers and fused-shape derivation sequencer.
module tprg_fuse import tprg_pkg::*; #(
    parameter int MAX_RANK    = MAX_RANK_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    localparam int RW = ($clog2(MAX_RANK + 1) > 3) ? $clog2(MAX_RANK + 1) : 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [LO_BITS-1:0]        cfg_data,
    output logic                      ready,
    output logic [RW-1:0]             outer_axes,
    output logic [COUNT_BITS-1:0]     radix [MAX_RANK],
    output logic [WORD_BITS-1:0]      src_stride [MAX_RANK],
    output logic [WORD_BITS-1:0]      dst_stride [MAX_RANK],
    output desc_t                     desc
);

    localparam int IW    = $clog2(MAX_RANK);
    localparam int AXES  = 2 ** FIELD_BITS;
    localparam int LW    = AXES * LENGTH_BITS;
    localparam int OW    = FIELD_BITS * MAX_RANK;

    localparam logic [3:0] S_START = 4'd0;
    localparam logic [3:0] S_TAIL  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_SEAL  = 4'd3;
    localparam logic [3:0] S_DST   = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_TOP   = 4'd6;
    localparam logic [3:0] S_SWAP  = 4'd7;
    localparam logic [3:0] S_PREP  = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_READY = 4'd11;

    logic [2:0]            rank_reg;
    logic [ORDER_BITS-1:0] order_reg;
    logic [LO_BITS-1:0]    lo_reg;
    logic [HI_BITS-1:0]    hi_reg;

    logic [3:0]            state_reg, state_next;
    logic [RW-1:0]         idx_reg, idx_next;
    logic [RW-1:0]         k_reg, k_next;
    logic [RW-1:0]         b_reg, b_next;
    logic [FIELD_BITS-1:0] prev_reg, prev_next;
    logic                  prev_ok_reg, prev_ok_next;
    logic [WORD_BITS-1:0]  acc_reg, acc_next;
    logic [COUNT_BITS-1:0] sacc_reg, sacc_next;
    logic [1:0]            found_reg, found_next;
    logic [WORD_BITS-1:0]  m1_reg, m1_next, m2_reg, m2_next, m3_reg, m3_next;
    logic                  m1l_reg, m1l_next, m2l_reg, m2l_next, m3l_reg, m3l_next;
    logic [WORD_BITS-1:0]  len_reg [MAX_RANK];
    logic [WORD_BITS-1:0]  len_next [MAX_RANK];
    logic [WORD_BITS-1:0]  ss_reg [MAX_RANK];
    logic [WORD_BITS-1:0]  ss_next [MAX_RANK];
    logic [WORD_BITS-1:0]  ds_reg [MAX_RANK];
    logic [WORD_BITS-1:0]  ds_next [MAX_RANK];
    logic [WORD_BITS-1:0]  tp_reg [MAX_RANK];
    logic [WORD_BITS-1:0]  tp_next [MAX_RANK];
    logic [COUNT_BITS-1:0] m_reg [MAX_RANK];
    logic [COUNT_BITS-1:0] m_next [MAX_RANK];
    desc_t                 desc_reg, desc_next;

    logic [LW+HI_BITS+LO_BITS-1:0] lw;
    logic [OW+ORDER_BITS-1:0]      ov;
    logic [RW-1:0]                 n;
    logic [FIELD_BITS-1:0]         ax;
    logic [FIELD_BITS-1:0]         sel_ax;
    logic [LENGTH_BITS-1:0]        raw_len;
    logic [WORD_BITS-1:0]          alen;
    logic                          take;
    logic [2*WORD_BITS-1:0]        prod;
    logic [COUNT_BITS+WORD_BITS-1:0] sprod;
    logic [WORD_BITS+1:0]          tail_sum;
    logic [WORD_BITS-1:0]          v;
    logic [RW-1:0]                 last;
    logic [IW-1:0]                 km1;
    logic [IW-1:0]                 ix;
    logic [WORD_BITS-1:0]          sz [3];
    logic [WORD_BITS-1:0]          sst [3];
    logic [WORD_BITS-1:0]          dstr [3];

    assign lw = {{LW{1'b0}}, hi_reg, lo_reg};
    assign ov = {{OW{1'b0}}, order_reg};

    always_comb
    begin
        if (rank_reg == 3'd0)
            n = RW'(1);
        else if (RW'(rank_reg) > RW'(MAX_RANK))
            n = RW'(MAX_RANK);
        else
            n = RW'(rank_reg);
    end

    assign ax      = ov[idx_reg * FIELD_BITS +: FIELD_BITS];
    assign sel_ax  = (state_reg == S_TAIL) ? FIELD_BITS'(idx_reg) : ax;
    assign raw_len = lw[sel_ax * LENGTH_BITS +: LENGTH_BITS];
    assign alen    = (raw_len == '0) ? WORD_BITS'(1) : WORD_BITS'(raw_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg  <= RANK_RESET;
            order_reg <= ORDER_RESET;
            lo_reg    <= LO_RESET;
            hi_reg    <= HI_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RANK:  rank_reg  <= cfg_data[2:0];
                REG_ORDER: order_reg <= cfg_data[ORDER_BITS-1:0];
                REG_LO:    lo_reg    <= cfg_data;
                REG_HI:    hi_reg    <= cfg_data[HI_BITS-1:0];
                default:   rank_reg  <= rank_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        b_next       = b_reg;
        prev_next    = prev_reg;
        prev_ok_next = prev_ok_reg;
        acc_next     = acc_reg;
        sacc_next    = sacc_reg;
        found_next   = found_reg;
        m1_next      = m1_reg;
        m2_next      = m2_reg;
        m3_next      = m3_reg;
        m1l_next     = m1l_reg;
        m2l_next     = m2l_reg;
        m3l_next     = m3l_reg;
        len_next     = len_reg;
        ss_next      = ss_reg;
        ds_next      = ds_reg;
        tp_next      = tp_reg;
        m_next       = m_reg;
        desc_next    = desc_reg;
        take         = 1'b0;
        prod         = '0;
        sprod        = '0;
        tail_sum     = '0;
        v            = '0;
        last         = '0;
        km1          = IW'(k_reg - RW'(1));
        ix           = '0;
        for (int j = 0; j < 3; j++)
        begin
            sz[j]   = WORD_BITS'(1);
            sst[j]  = '0;
            dstr[j] = '0;
        end

        case (state_reg)
            S_START:
            begin
                acc_next     = WORD_BITS'(1);
                idx_next     = n - RW'(1);
                k_next       = '0;
                prev_ok_next = 1'b0;
                for (int i = 0; i < MAX_RANK; i++)
                begin
                    len_next[i] = WORD_BITS'(1);
                    ss_next[i]  = '0;
                    ds_next[i]  = '0;
                end
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                tp_next[IW'(idx_reg)] = acc_reg;
                prod     = acc_reg * alen;
                acc_next = prod[WORD_BITS-1:0];
                if (idx_reg == '0)
                    state_next = S_SCAN;
                else
                    idx_next = idx_reg - RW'(1);
            end
            S_SCAN:
            begin
                take = (idx_reg < n) && (RW'(ax) < n) && (alen != WORD_BITS'(1));
                if (take)
                begin
                    if (prev_ok_reg && ({1'b0, ax} == {1'b0, prev_reg} + 4'd1))
                    begin
                        prod          = len_reg[km1] * alen;
                        len_next[km1] = prod[WORD_BITS-1:0];
                    end
                    else
                    begin
                        if (prev_ok_reg)
                            ss_next[km1] = tp_reg[IW'(prev_reg)];
                        len_next[IW'(k_reg)] = alen;
                        k_next = k_reg + RW'(1);
                    end
                    prev_next    = ax;
                    prev_ok_next = 1'b1;
                end
                if (idx_reg == RW'(MAX_RANK - 1))
                    state_next = S_SEAL;
                else
                    idx_next = idx_reg + RW'(1);
            end
            S_SEAL:
            begin
                if (prev_ok_reg)
                    ss_next[km1] = tp_reg[IW'(prev_reg)];
                acc_next = WORD_BITS'(1);
                idx_next = k_reg - RW'(1);
                state_next = (k_reg == '0) ? S_CHK : S_DST;
            end
            S_DST:
            begin
                ds_next[IW'(idx_reg)] = acc_reg;
                prod     = acc_reg * len_reg[IW'(idx_reg)];
                acc_next = prod[WORD_BITS-1:0];
                if (idx_reg == '0)
                    state_next = S_CHK;
                else
                    idx_next = idx_reg - RW'(1);
            end
            S_CHK:
            begin
                tail_sum = (WORD_BITS+2)'(len_reg[IW'(1)]) + (WORD_BITS+2)'(len_reg[IW'(2)])
                         + (WORD_BITS+2)'(len_reg[IW'(MAX_RANK > 3 ? 3 : MAX_RANK - 1)]);
                m1_next  = len_reg[0];
                m1l_next = 1'b1;
                m2l_next = 1'b0;
                m3l_next = 1'b0;
                idx_next = RW'(1);
                if ((k_reg > RW'(4)) ||
                    ((k_reg == RW'(4)) && ((WORD_BITS+2)'(len_reg[0]) > tail_sum)))
                    state_next = S_TOP;
                else
                    state_next = S_PREP;
            end
            S_TOP:
            begin
                v = len_reg[IW'(idx_reg)];
                if (!m1l_reg || v > m1_reg)
                begin
                    m3_next  = m2_reg;
                    m3l_next = m2l_reg;
                    m2_next  = m1_reg;
                    m2l_next = m1l_reg;
                    m1_next  = v;
                    m1l_next = 1'b1;
                end
                else if (!m2l_reg || v > m2_reg)
                begin
                    m3_next  = m2_reg;
                    m3l_next = m2l_reg;
                    m2_next  = v;
                    m2l_next = 1'b1;
                end
                else if (!m3l_reg || v > m3_reg)
                begin
                    m3_next  = v;
                    m3l_next = 1'b1;
                end
                if (idx_reg == k_reg - RW'(1))
                begin
                    idx_next   = k_reg - RW'(1);
                    found_next = '0;
                    state_next = S_SWAP;
                end
                else
                    idx_next = idx_reg + RW'(1);
            end
            S_SWAP:
            begin
                v    = len_reg[IW'(idx_reg)];
                last = k_reg - RW'(1) - RW'(found_reg);
                if ((m1l_reg && v == m1_reg) || (m2l_reg && v == m2_reg) ||
                    (m3l_reg && v == m3_reg))
                begin
                    if (idx_reg != last)
                    begin
                        len_next[IW'(idx_reg)] = len_reg[IW'(last)];
                        len_next[IW'(last)]    = len_reg[IW'(idx_reg)];
                        ss_next[IW'(idx_reg)]  = ss_reg[IW'(last)];
                        ss_next[IW'(last)]     = ss_reg[IW'(idx_reg)];
                        ds_next[IW'(idx_reg)]  = ds_reg[IW'(last)];
                        ds_next[IW'(last)]     = ds_reg[IW'(idx_reg)];
                    end
                    if (m1l_reg && v == m1_reg)
                        m1l_next = 1'b0;
                    else if (m2l_reg && v == m2_reg)
                        m2l_next = 1'b0;
                    else
                        m3l_next = 1'b0;
                    found_next = found_reg + 2'd1;
                end
                if (found_next == 2'd3 || idx_reg == '0)
                    state_next = S_PREP;
                else
                    idx_next = idx_reg - RW'(1);
            end
            S_PREP:
            begin
                b_next    = (k_reg >= RW'(3)) ? k_reg - RW'(3) : '0;
                sacc_next = COUNT_BITS'(1);
                idx_next  = b_next - RW'(1);
                state_next = (b_next == '0) ? S_FIN : S_MUL;
            end
            S_MUL:
            begin
                m_next[IW'(idx_reg)] = sacc_reg;
                sprod = sacc_reg * len_reg[IW'(idx_reg)];
                if (sprod > (COUNT_BITS+WORD_BITS)'(REGION_CAP))
                    sacc_next = REGION_CAP;
                else
                    sacc_next = sprod[COUNT_BITS-1:0];
                if (idx_reg == '0)
                    state_next = S_FIN;
                else
                    idx_next = idx_reg - RW'(1);
            end
            S_FIN:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (RW'(j) < k_reg)
                    begin
                        ix          = IW'(k_reg - RW'(j + 1));
                        sz[2-j]     = len_reg[ix];
                        sst[2-j]    = ss_reg[ix];
                        dstr[2-j]   = ds_reg[ix];
                    end
                    else if (k_reg == '0)
                    begin
                        sst[2-j]  = WORD_BITS'(1);
                        dstr[2-j] = WORD_BITS'(1);
                    end
                end
                desc_next.region_count      = sacc_reg;
                desc_next.outer_size        = (sz[0] > WORD_BITS'(SIZE_CAP)) ? SIZE_CAP
                                                                            : sz[0][SIZE_BITS-1:0];
                desc_next.middle_size       = (sz[1] > WORD_BITS'(SIZE_CAP)) ? SIZE_CAP
                                                                            : sz[1][SIZE_BITS-1:0];
                desc_next.inner_size        = sz[2];
                desc_next.src_outer_stride  = sst[0];
                desc_next.src_middle_stride = sst[1];
                desc_next.src_inner_stride  = sst[2];
                desc_next.dst_outer_stride  = dstr[0];
                desc_next.dst_middle_stride = dstr[1];
                desc_next.dst_inner_stride  = dstr[2];
                state_next = S_READY;
            end
            S_READY:
            begin
                state_next = S_READY;
            end
            default:
            begin
                state_next = S_START;
            end
        endcase

        if (cfg_write && (cfg_index == REG_RANK || cfg_index == REG_ORDER ||
                          cfg_index == REG_LO || cfg_index == REG_HI))
            state_next = S_START;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_START;
            k_reg       <= '0;
            b_reg       <= '0;
            prev_ok_reg <= 1'b0;
            found_reg   <= '0;
            m1l_reg     <= 1'b0;
            m2l_reg     <= 1'b0;
            m3l_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            b_reg       <= b_next;
            prev_ok_reg <= prev_ok_next;
            found_reg   <= found_next;
            m1l_reg     <= m1l_next;
            m2l_reg     <= m2l_next;
            m3l_reg     <= m3l_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        prev_reg <= prev_next;
        acc_reg  <= acc_next;
        sacc_reg <= sacc_next;
        m1_reg   <= m1_next;
        m2_reg   <= m2_next;
        m3_reg   <= m3_next;
        len_reg  <= len_next;
        ss_reg   <= ss_next;
        ds_reg   <= ds_next;
        tp_reg   <= tp_next;
        m_reg    <= m_next;
        desc_reg <= desc_next;
    end

    assign ready      = (state_reg == S_READY);
    assign outer_axes = b_reg;
    assign radix      = m_reg;
    assign src_stride = ss_reg;
    assign dst_stride = ds_reg;
    assign desc       = desc_reg;

endmodule

// ===== rtl/core/tprg_cell.sv =====
// One mixed-radix decode cell: bit-serial divide, then stride accumulate.
module tprg_cell import tprg_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  active,
    input  logic [INDEX_BITS-1:0] value_in,
    input  logic [WORD_BITS-1:0]  so_in,
    input  logic [WORD_BITS-1:0]  do_in,
    input  logic [COUNT_BITS-1:0] divisor,
    input  logic [WORD_BITS-1:0]  src_stride,
    input  logic [WORD_BITS-1:0]  dst_stride,
    output logic                  done,
    output logic [INDEX_BITS-1:0] value_out,
    output logic [WORD_BITS-1:0]  so_out,
    output logic [WORD_BITS-1:0]  do_out
);

    localparam int CW = $clog2(INDEX_BITS);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_DIV  = 2'd1;
    localparam logic [1:0] C_ACC  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [INDEX_BITS-1:0] val_reg, val_next;
    logic [INDEX_BITS-1:0] rem_reg, rem_next;
    logic [INDEX_BITS-1:0] quo_reg, quo_next;
    logic [INDEX_BITS-1:0] vout_reg, vout_next;
    logic [WORD_BITS-1:0]  so_reg, so_next;
    logic [WORD_BITS-1:0]  do_reg, do_next;
    logic [COUNT_BITS-1:0] trial;
    logic [INDEX_BITS+WORD_BITS-1:0] sp, dp;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        vout_next  = vout_reg;
        so_next    = so_reg;
        do_next    = do_reg;
        trial      = {rem_reg, val_reg[INDEX_BITS-1]};
        sp         = quo_reg * src_stride;
        dp         = quo_reg * dst_stride;

        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    so_next   = so_in;
                    do_next   = do_in;
                    val_next  = value_in;
                    vout_next = value_in;
                    rem_next  = '0;
                    quo_next  = '0;
                    cnt_next  = '0;
                    if (active && divisor != '0)
                        state_next = C_DIV;
                    else
                        done_next = 1'b1;
                end
            end
            C_DIV:
            begin
                if (trial >= divisor)
                begin
                    rem_next = INDEX_BITS'(trial - divisor);
                    quo_next = {quo_reg[INDEX_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[INDEX_BITS-1:0];
                    quo_next = {quo_reg[INDEX_BITS-2:0], 1'b0};
                end
                val_next = {val_reg[INDEX_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(INDEX_BITS - 1))
                    state_next = C_ACC;
            end
            C_ACC:
            begin
                so_next    = so_reg + sp[WORD_BITS-1:0];
                do_next    = do_reg + dp[WORD_BITS-1:0];
                vout_next  = rem_reg;
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        vout_reg <= vout_next;
        so_reg   <= so_next;
        do_reg   <= do_next;
    end

    assign done      = done_reg;
    assign value_out = vout_reg;
    assign so_out    = so_reg;
    assign do_out    = do_reg;

endmodule

// ===== rtl/core/tensor_permute_region_generator.sv =====
// Top level of the tensor permute region generator.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//   in      | in_valid / in_ready    | region_index
//   out     | out_valid / out_ready  | offsets, sizes, strides, region_count
//
// After reset and after each register write the shape sequencer runs with in_ready low.
// An item then walks the row of decode cells: a fused outer axis takes a bit-serial
// divide, an accumulate and a handoff; a cell beyond the outer axes hands it straight
// on; the result then goes to the output register.
// A beat whose index is not below region_count is taken and dropped.
// A finished beat waits in the output register while the next item is taken.
module tensor_permute_region_generator import tprg_pkg::*; #(
    parameter int MAX_RANK    = MAX_RANK_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [LO_BITS-1:0]        cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [INDEX_BITS-1:0]     region_index,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [WORD_BITS-1:0]      src_offset,
    output logic [WORD_BITS-1:0]      dst_offset,
    output logic [SIZE_BITS-1:0]      outer_size,
    output logic [SIZE_BITS-1:0]      middle_size,
    output logic [WORD_BITS-1:0]      inner_size,
    output logic [WORD_BITS-1:0]      src_outer_stride,
    output logic [WORD_BITS-1:0]      src_middle_stride,
    output logic [WORD_BITS-1:0]      src_inner_stride,
    output logic [WORD_BITS-1:0]      dst_outer_stride,
    output logic [WORD_BITS-1:0]      dst_middle_stride,
    output logic [WORD_BITS-1:0]      dst_inner_stride,
    output logic [COUNT_BITS-1:0]     region_count
);

    localparam int RW = ($clog2(MAX_RANK + 1) > 3) ? $clog2(MAX_RANK + 1) : 3;
    localparam int NC = (MAX_RANK > 3) ? MAX_RANK - 3 : 1;

    logic                  shape_ready;
    logic [RW-1:0]         outer_axes;
    logic [COUNT_BITS-1:0] radix [MAX_RANK];
    logic [WORD_BITS-1:0]  sstr [MAX_RANK];
    logic [WORD_BITS-1:0]  dstr [MAX_RANK];
    desc_t                 desc;

    logic                  go [NC+1];
    logic [INDEX_BITS-1:0] cval [NC+1];
    logic [WORD_BITS-1:0]  cso [NC+1];
    logic [WORD_BITS-1:0]  cdo [NC+1];

    logic                  busy_reg, busy_next;
    logic                  fin_reg, fin_next;
    logic                  ov_reg, ov_next;
    logic [WORD_BITS-1:0]  so_reg, do_reg;
    desc_t                 desc_reg;
    logic                  accept, hit, load;

    assign cfg_ready = 1'b1;

    tprg_fuse #(
        .MAX_RANK    (MAX_RANK),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_fuse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ready      (shape_ready),
        .outer_axes (outer_axes),
        .radix      (radix),
        .src_stride (sstr),
        .dst_stride (dstr),
        .desc       (desc)
    );

    assign in_ready = !busy_reg && shape_ready;
    assign accept   = in_valid && in_ready;
    assign hit      = COUNT_BITS'(region_index) < desc.region_count;

    assign go[0]   = accept && hit;
    assign cval[0] = region_index;
    assign cso[0]  = '0;
    assign cdo[0]  = '0;

    for (genvar gi = 0; gi < NC; gi++)
    begin : g_cell
        tprg_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .start      (go[gi]),
            .active     (RW'(gi) < outer_axes),
            .value_in   (cval[gi]),
            .so_in      (cso[gi]),
            .do_in      (cdo[gi]),
            .divisor    (radix[gi]),
            .src_stride (sstr[gi]),
            .dst_stride (dstr[gi]),
            .done       (go[gi+1]),
            .value_out  (cval[gi+1]),
            .so_out     (cso[gi+1]),
            .do_out     (cdo[gi+1])
        );
    end

    assign load = fin_reg && (!ov_reg || out_ready);

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = fin_reg;
        ov_next   = ov_reg;
        if (go[0])
            busy_next = 1'b1;
        if (go[NC])
            fin_next = 1'b1;
        if (load)
        begin
            fin_next  = 1'b0;
            busy_next = 1'b0;
            ov_next   = 1'b1;
        end
        else if (out_ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            so_reg   <= cso[NC];
            do_reg   <= cdo[NC];
            desc_reg <= desc;
        end
    end

    assign out_valid         = ov_reg;
    assign src_offset        = so_reg;
    assign dst_offset        = do_reg;
    assign outer_size        = desc_reg.outer_size;
    assign middle_size       = desc_reg.middle_size;
    assign inner_size        = desc_reg.inner_size;
    assign src_outer_stride  = desc_reg.src_outer_stride;
    assign src_middle_stride = desc_reg.src_middle_stride;
    assign src_inner_stride  = desc_reg.src_inner_stride;
    assign dst_outer_stride  = desc_reg.dst_outer_stride;
    assign dst_middle_stride = desc_reg.dst_middle_stride;
    assign dst_inner_stride  = desc_reg.dst_inner_stride;
    assign region_count      = desc_reg.region_count;

endmodule

// ===== test/tb_tensor_permute_region_generator.sv =====
// Testbench for the tensor permute region generator: directed and random shapes, scored per beat.
`timescale 1ns / 100ps

module tb_tensor_permute_region_generator;
    import tprg_pkg::*;

    typedef struct {
        logic [WORD_BITS-1:0] src_off;
        logic [WORD_BITS-1:0] dst_off;
        desc_t                d;
    } region_desc_t;

    typedef struct {
        bit                        is_cfg;
        logic [CFG_INDEX_BITS-1:0] reg_idx;
        logic [LO_BITS-1:0]        data;
        logic [INDEX_BITS-1:0]     idx;
        bit                        typed;
        bit                        typed_drop;
        region_desc_t              want;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [LO_BITS-1:0]        cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [INDEX_BITS-1:0]     region_index;
    logic                      out_valid;
    logic                      out_ready;
    logic [WORD_BITS-1:0]      src_offset;
    logic [WORD_BITS-1:0]      dst_offset;
    logic [SIZE_BITS-1:0]      outer_size;
    logic [SIZE_BITS-1:0]      middle_size;
    logic [WORD_BITS-1:0]      inner_size;
    logic [WORD_BITS-1:0]      src_outer_stride;
    logic [WORD_BITS-1:0]      src_middle_stride;
    logic [WORD_BITS-1:0]      src_inner_stride;
    logic [WORD_BITS-1:0]      dst_outer_stride;
    logic [WORD_BITS-1:0]      dst_middle_stride;
    logic [WORD_BITS-1:0]      dst_inner_stride;
    logic [COUNT_BITS-1:0]     region_count;

    tensor_permute_region_generator dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .region_index      (region_index),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .src_offset        (src_offset),
        .dst_offset        (dst_offset),
        .outer_size        (outer_size),
        .middle_size       (middle_size),
        .inner_size        (inner_size),
        .src_outer_stride  (src_outer_stride),
        .src_middle_stride (src_middle_stride),
        .src_inner_stride  (src_inner_stride),
        .dst_outer_stride  (dst_outer_stride),
        .dst_middle_stride (dst_middle_stride),
        .dst_inner_stride  (dst_inner_stride),
        .region_count      (region_count)
    );

    logic [2:0]            shp_rank;
    logic [ORDER_BITS-1:0] shp_order;
    logic [LO_BITS-1:0]    shp_lo;
    logic [HI_BITS-1:0]    shp_hi;
    logic [31:0]           fz_len [MAX_RANK_DEF];
    logic [31:0]           fz_ss  [MAX_RANK_DEF];
    logic [31:0]           fz_ds  [MAX_RANK_DEF];
    int                    fz_rank;
    longint unsigned       fz_regions;

    region_desc_t pending_regions [$];
    stim_row_t    rows [$];
    int           errors;
    bit           no_idle;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] axis_len(int a);
        logic [95:0] word;
        logic [15:0] v;
        word = {shp_hi, shp_lo};
        v = (a < MAX_RANK_DEF) ? word[a*16 +: 16] : 16'd0;
        return (v == 0) ? 32'd1 : {16'd0, v};
    endfunction

    function automatic logic [31:0] tail_len(int after, int n);
        logic [31:0] p;
        p = 1;
        for (int v = after + 1; v < n; v++)
            p = p * axis_len(v);
        return p;
    endfunction

    function automatic longint unsigned sat_mul(longint unsigned a, longint unsigned b,
                                                longint unsigned cap);
        if (a == 0 || b == 0)
            return 0;
        if (a > cap / b)
            return cap;
        a = a * b;
        return (a > cap) ? cap : a;
    endfunction

    function automatic void rebuild_shape();
        logic [31:0] len [MAX_RANK_DEF];
        logic [31:0] ss  [MAX_RANK_DEF];
        logic [31:0] ds  [MAX_RANK_DEF];
        logic [31:0] s, t, l;
        int n, k, prev, a, last, b;
        bit reorder;
        longint m1, m2, m3, v;
        n = shp_rank;
        k = 0;
        prev = -2;
        if (n < 1) n = 1;
        if (n > MAX_RANK_DEF) n = MAX_RANK_DEF;
        for (int i = 0; i < MAX_RANK_DEF; i++)
        begin
            len[i] = 1;
            ss[i] = 0;
            ds[i] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            a = (shp_order >> (3 * i)) & 7;
            if (a >= n) continue;
            l = axis_len(a);
            if (l == 1) continue;
            if (prev >= 0 && a == prev + 1)
                len[k-1] = len[k-1] * l;
            else
            begin
                if (prev >= 0) ss[k-1] = tail_len(prev, n);
                len[k] = l;
                k++;
            end
            prev = a;
        end
        if (prev >= 0) ss[k-1] = tail_len(prev, n);
        s = 1;
        for (int j = k - 1; j >= 0; j--)
        begin
            ds[j] = s;
            s = s * len[j];
        end
        reorder = k > 4;
        if (k == 4)
            reorder = 64'(len[0]) > 64'(len[1]) + 64'(len[2]) + 64'(len[3]);
        if (reorder)
        begin
            m1 = len[0];
            m2 = -1;
            m3 = -1;
            last = k - 1;
            for (int j = 1; j < k; j++)
            begin
                v = len[j];
                if (v > m1) begin m3 = m2; m2 = m1; m1 = v; end
                else if (v > m2) begin m3 = m2; m2 = v; end
                else if (v > m3) m3 = v;
            end
            for (int j = k - 1; j >= 0; j--)
            begin
                v = len[j];
                if (v == m1 || v == m2 || v == m3)
                begin
                    if (j != last)
                    begin
                        t = len[j]; len[j] = len[last]; len[last] = t;
                        t = ss[j];  ss[j]  = ss[last];  ss[last]  = t;
                        t = ds[j];  ds[j]  = ds[last];  ds[last]  = t;
                    end
                    if (v == m1) m1 = -1;
                    else if (v == m2) m2 = -1;
                    else m3 = -1;
                    last--;
                end
                if (last < k - 3) break;
            end
        end
        fz_len = len;
        fz_ss = ss;
        fz_ds = ds;
        fz_rank = k;
        fz_regions = 1;
        b = (k >= 3) ? k - 3 : 0;
        for (int i = 0; i < b; i++)
            fz_regions = sat_mul(fz_regions, fz_len[i], 65536);
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_BITS-1:0] r, logic [LO_BITS-1:0] d);
        case (r)
            REG_RANK:  shp_rank = d[2:0];
            REG_ORDER: shp_order = d[ORDER_BITS-1:0];
            REG_LO:    shp_lo = d;
            REG_HI:    shp_hi = d[HI_BITS-1:0];
            default:   return;
        endcase
        rebuild_shape();
    endfunction

    function automatic bit predict_region(logic [INDEX_BITS-1:0] idx, output region_desc_t r);
        int k, b;
        longint unsigned value, m, c;
        logic [31:0] so, dof;
        logic [31:0] sz [3];
        logic [31:0] sst [3];
        logic [31:0] dst [3];
        k = fz_rank;
        r.src_off = 0;
        r.dst_off = 0;
        if (k == 0)
        begin
            r.d = '{region_count: 1, outer_size: 1, middle_size: 1, inner_size: 1,
                    src_outer_stride: 1, src_middle_stride: 1, src_inner_stride: 1,
                    dst_outer_stride: 1, dst_middle_stride: 1, dst_inner_stride: 1};
            return idx == 0;
        end
        for (int j = 0; j < 3; j++)
        begin
            sz[j] = 1;
            sst[j] = 0;
            dst[j] = 0;
        end
        for (int j = 0; j < 3 && j < k; j++)
        begin
            sz[2-j] = fz_len[k-1-j];
            sst[2-j] = fz_ss[k-1-j];
            dst[2-j] = fz_ds[k-1-j];
        end
        b = (k >= 3) ? k - 3 : 0;
        if (idx >= fz_regions)
            return 0;
        value = idx;
        so = 0;
        dof = 0;
        for (int i = 0; i < b; i++)
        begin
            m = 1;
            for (int j = i + 1; j < b; j++)
                m = sat_mul(m, fz_len[j], 65536);
            if (m == 0)
                c = 0;
            else
            begin
                c = value / m;
                value = value % m;
            end
            so = so + 32'(c) * fz_ss[i];
            dof = dof + 32'(c) * fz_ds[i];
        end
        r.src_off = so;
        r.dst_off = dof;
        r.d.outer_size = (sz[0] > 65535) ? SIZE_CAP : sz[0][15:0];
        r.d.middle_size = (sz[1] > 65535) ? SIZE_CAP : sz[1][15:0];
        r.d.inner_size = sz[2];
        r.d.src_outer_stride = sst[0];
        r.d.src_middle_stride = sst[1];
        r.d.src_inner_stride = sst[2];
        r.d.dst_outer_stride = dst[0];
        r.d.dst_middle_stride = dst[1];
        r.d.dst_inner_stride = dst[2];
        r.d.region_count = fz_regions[16:0];
        return 1;
    endfunction

    function automatic int draw_gap();
        if (no_idle) return 0;
        return $urandom_range(0, 11);
    endfunction

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] r, logic [LO_BITS-1:0] d);
        in_valid <= 1'b0;
        while (pending_regions.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        apply_reg(r, d);
    endtask

    task automatic send_index(logic [INDEX_BITS-1:0] idx, bit typed, bit typed_drop,
                              region_desc_t want);
        region_desc_t r;
        bit hit;
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        region_index <= idx;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        hit = predict_region(idx, r);
        if (typed)
        begin
            if (!typed_drop) pending_regions.push_back(want);
        end
        else if (hit)
            pending_regions.push_back(r);
    endtask

    function automatic void add_cfg(logic [CFG_INDEX_BITS-1:0] r, logic [LO_BITS-1:0] d);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg = 1;
        row.reg_idx = r;
        row.data = d;
        rows.push_back(row);
    endfunction

    function automatic void add_item(logic [INDEX_BITS-1:0] idx);
        stim_row_t row;
        row = '{default: '0};
        row.idx = idx;
        rows.push_back(row);
    endfunction

    function automatic logic [15:0] draw_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 30) return 1;
        if (p < 70) return $urandom_range(1, 4);
        if (p < 85) return $urandom_range(5, 40);
        if (p < 95) return $urandom_range(0, 65535);
        return 0;
    endfunction

    task automatic random_phase(int items);
        logic [2:0] r;
        logic [ORDER_BITS-1:0] ord;
        logic [95:0] lens;
        int perm [MAX_RANK_DEF];
        int n, j, t;
        region_desc_t none;
        none = '{default: '0};
        r = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(2, 6)) : 3'($urandom_range(0, 7));
        n = (r == 0) ? 1 : ((r > MAX_RANK_DEF) ? MAX_RANK_DEF : r);
        ord = 18'($urandom());
        if ($urandom_range(0, 9) < 7)
        begin
            for (int i = 0; i < MAX_RANK_DEF; i++) perm[i] = i;
            for (int i = n - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                t = perm[i]; perm[i] = perm[j]; perm[j] = t;
            end
            for (int i = 0; i < n; i++) ord[3*i +: 3] = 3'(perm[i]);
        end
        for (int i = 0; i < MAX_RANK_DEF; i++) lens[16*i +: 16] = draw_length();
        if ($urandom_range(0, 19) == 0) lens[63:0] = {$urandom(), $urandom()};
        if ($urandom_range(0, 19) == 0) lens[95:64] = $urandom();
        write_reg(REG_RANK, 64'(r));
        write_reg(REG_ORDER, 64'(ord));
        write_reg(REG_LO, lens[63:0]);
        write_reg(REG_HI, 64'(lens[95:64]));
        no_idle = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(0, 99) < 85)
                send_index(16'($urandom_range(0, int'(fz_regions) - 1)), 0, 0, none);
            else
                send_index(16'($urandom_range(0, 65535)), 0, 0, none);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        region_index = '0;
        out_ready = 1'b0;
        errors = 0;
        no_idle = 0;
        shp_rank = RANK_RESET;
        shp_order = ORDER_RESET;
        shp_lo = LO_RESET;
        shp_hi = HI_RESET;
        rebuild_shape();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // after reset: single full slice, anything else dropped
        rows.push_back('{is_cfg: 0, reg_idx: 0, data: 0, idx: 0, typed: 1, typed_drop: 0,
            want: '{src_off: 0, dst_off: 0, d: '{region_count: 1, outer_size: 1,
                middle_size: 1, inner_size: 1, src_outer_stride: 1, src_middle_stride: 1,
                src_inner_stride: 1, dst_outer_stride: 1, dst_middle_stride: 1,
                dst_inner_stride: 1}}});
        rows.push_back('{is_cfg: 0, reg_idx: 0, data: 0, idx: 16'hFFFF, typed: 1,
            typed_drop: 1, want: '{default: '0}});
        add_cfg(REG_RANK, 64'd0);
        add_item(16'd0);
        add_cfg(REG_RANK, 64'd7);
        add_cfg(REG_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        add_cfg(REG_HI, 64'hFFFF_FFFF);
        add_item(16'd0);
        add_item(16'hFFFF);
        add_cfg(REG_ORDER, 64'd5349);
        add_item(16'd1234);
        add_cfg(REG_LO, 64'h0005_0000_0003_0002);
        add_cfg(REG_HI, 64'h0007_0004);
        add_item(16'd0);
        add_item(16'd5);
        add_cfg(REG_ORDER, 64'd0);
        add_item(16'd0);
        add_cfg(REG_ORDER, 64'h3FFFF);
        add_item(16'd0);
        add_cfg(REG_ORDER, 64'd181896);
        add_cfg(REG_LO, 64'h0002_0100_0001_0200);
        add_item(16'd3);
        add_cfg(REG_LO, 64'h0000_0000_0000_0000);
        add_cfg(REG_HI, 64'h0000_0000);
        add_item(16'd0);
        add_item(16'd1);

        for (int i = 0; i < rows.size(); i++)
        begin
            if (rows[i].is_cfg)
                write_reg(rows[i].reg_idx, rows[i].data);
            else
                send_index(rows[i].idx, rows[i].typed, rows[i].typed_drop, rows[i].want);
        end
        for (int ph = 0; ph < 28; ph++)
            random_phase(50);

        in_valid <= 1'b0;
        while (pending_regions.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_valid);
            @(posedge clk);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    always @(negedge clk)
    begin
        region_desc_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_regions.size() == 0)
            begin
                errors++;
                $display("%0t unexpected beat expected none actual src_offset %h",
                         $time, src_offset);
            end
            else
            begin
                w = pending_regions.pop_front();
                check_field("src_offset", w.src_off, src_offset);
                check_field("dst_offset", w.dst_off, dst_offset);
                check_field("outer_size", 32'(w.d.outer_size), 32'(outer_size));
                check_field("middle_size", 32'(w.d.middle_size), 32'(middle_size));
                check_field("inner_size", w.d.inner_size, inner_size);
                check_field("src_outer_stride", w.d.src_outer_stride, src_outer_stride);
                check_field("src_middle_stride", w.d.src_middle_stride, src_middle_stride);
                check_field("src_inner_stride", w.d.src_inner_stride, src_inner_stride);
                check_field("dst_outer_stride", w.d.dst_outer_stride, dst_outer_stride);
                check_field("dst_middle_stride", w.d.dst_middle_stride, dst_middle_stride);
                check_field("dst_inner_stride", w.d.dst_inner_stride, dst_inner_stride);
                check_field("region_count", 32'(w.d.region_count), 32'(region_count));
            end
        end
    end

    initial
    begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tprg_pkg.sv
rtl/core/tprg_fuse.sv
rtl/core/tprg_cell.sv
rtl/core/tensor_permute_region_generator.sv
test/tb_tensor_permute_region_generator.sv
